@@ hw/rtl/cab_pkg.sv @@
// Shared types, codes and arithmetic helpers for the clipped alpha blit block.
`default_nettype none

package cab_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY     = 3'd4;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_BLEND = 2'd2;

    localparam logic [7:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       in_frame;
    } out_item_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Exact floor(x / 255) for x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cab_blend.sv @@
// Two-stage source-over blend datapath for one RGBA pixel.
`default_nettype none

module cab_blend (
    input  wire logic            clk,
    input  wire cab_pkg::pixel_t dst,
    input  wire cab_pkg::pixel_t src,
    input  wire logic [7:0]      sa,
    output cab_pkg::pixel_t      blended
);
    import cab_pkg::*;

    logic [7:0]  inv_sa;
    logic [7:0]  dst_ch [4];
    logic [7:0]  src_ch [3];
    logic [15:0] keep_prod_reg [4];
    logic [15:0] src_prod_reg [3];
    logic [7:0]  sa_d_reg;
    logic [7:0]  out_ch_reg [4];

    always_comb
    begin
        inv_sa    = PIX_MAX - sa;
        dst_ch[0] = dst.red;
        dst_ch[1] = dst.green;
        dst_ch[2] = dst.blue;
        dst_ch[3] = dst.alpha;
        src_ch[0] = src.red;
        src_ch[1] = src.green;
        src_ch[2] = src.blue;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            keep_prod_reg[i] <= 16'(dst_ch[i]) * 16'(inv_sa);
        end
        for (int i = 0; i < 3; i++)
        begin
            src_prod_reg[i] <= 16'(src_ch[i]) * 16'(sa);
        end
        sa_d_reg <= sa;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_ch_reg[i] <= div255(16'(keep_prod_reg[i] + src_prod_reg[i]));
        end
        out_ch_reg[3] <= div255(keep_prod_reg[3]) + sa_d_reg;
    end

    assign blended.red   = out_ch_reg[0];
    assign blended.green = out_ch_reg[1];
    assign blended.blue  = out_ch_reg[2];
    assign blended.alpha = out_ch_reg[3];

endmodule

`default_nettype wire

@@ hw/rtl/clipped_alpha_blit.sv @@
// Top level of the clipped alpha blit: RGBA frame memory with write, read and blend.
//
// Items arrive on the item channel (valid/ready) and each gives exactly one beat on the
// result channel. Registers are written through the cfg channel, which is always ready.
// One item is worked on at a time over a single-port-write, registered-read frame memory:
//   write, out-of-frame or unused kind: accept, then finish before the next acceptance,
//   read: read, then finish; blend: read, multiply, divide by 255, write back, then finish.
// The result beat is loaded as the item leaves its finish state and sits in an output
// register, so a stalled receiver holds only that register; the next item is accepted
// and worked on meanwhile, and waits only when it finishes before the receiver takes
// the previous beat.
// After reset the block sweeps the frame memory to zero, one word per cycle, over all
// MAX_WIDTH * MAX_HEIGHT words (65536 with the default sizes); item_ready stays low
// during the sweep while configuration writes are still taken. Registers reset to a
// 256 by 256 frame at origin zero with full opacity.
`default_nettype none

module clipped_alpha_blit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire cab_pkg::in_item_t                 item,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output cab_pkg::out_item_t                     result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cab_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cab_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          result_valid_reg, result_valid_next;
    out_item_t     result_reg;

    logic [8:0] dest_width_reg, dest_height_reg, dest_x_reg, dest_y_reg;
    logic [7:0] opacity_reg;

    logic [31:0] mem [DEPTH];
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;
    pixel_t      rdata_reg;

    logic [1:0]    kind_reg;
    pixel_t        src_reg;
    logic [AW-1:0] addr_reg;
    logic [15:0]   prod_reg;
    logic [7:0]    sa_reg;
    pixel_t        res_pix_reg;
    logic          res_hit_reg;
    pixel_t        blended;

    logic        accept;
    logic        kind_ok;
    logic        is_blend;
    logic [9:0]  tx, ty;
    logic        hit_c;
    logic [31:0] addr_full;
    logic [AW-1:0] addr_c;
    logic        fin_go;
    pixel_t      item_pix;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign fin_go       = (state_reg == ST_FIN) && (!result_valid_reg || result_ready);

    always_comb
    begin
        item_pix.red   = item.red;
        item_pix.green = item.green;
        item_pix.blue  = item.blue;
        item_pix.alpha = item.alpha;
        kind_ok  = item.kind inside {KIND_WRITE, KIND_READ, KIND_BLEND};
        is_blend = (item.kind == KIND_BLEND);
        if (is_blend)
        begin
            tx = {dest_x_reg[8], dest_x_reg} + {2'b00, item.col};
            ty = {dest_y_reg[8], dest_y_reg} + {2'b00, item.row};
        end
        else
        begin
            tx = {2'b00, item.col};
            ty = {2'b00, item.row};
        end
        hit_c = kind_ok && !tx[9] && !ty[9]
                && (tx[8:0] < dest_width_reg) && (32'(tx[8:0]) < 32'(MAX_WIDTH))
                && (ty[8:0] < dest_height_reg) && (32'(ty[8:0]) < 32'(MAX_HEIGHT));
        addr_full = 32'(ty[8:0]) * 32'(MAX_WIDTH) + 32'(tx[8:0]);
        addr_c    = addr_full[AW-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        result_valid_next = result_valid_reg && !result_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (hit_c && (item.kind == KIND_READ || is_blend))
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = (kind_reg == KIND_READ) ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
            dest_width_reg   <= 9'd256;
            dest_height_reg  <= 9'd256;
            dest_x_reg       <= 9'd0;
            dest_y_reg       <= 9'd0;
            opacity_reg      <= PIX_MAX;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DEST_WIDTH:  dest_width_reg  <= cfg_data;
                    CFG_DEST_HEIGHT: dest_height_reg <= cfg_data;
                    CFG_DEST_X:      dest_x_reg      <= cfg_data;
                    CFG_DEST_Y:      dest_y_reg      <= cfg_data;
                    CFG_OPACITY:     opacity_reg     <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = blended;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                mem_we    = accept && hit_c && (item.kind == KIND_WRITE);
                mem_waddr = addr_c;
                mem_wdata = item_pix;
            end
            ST_WB:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= item.kind;
            src_reg     <= item_pix;
            addr_reg    <= addr_c;
            prod_reg    <= 16'(item.alpha) * 16'(opacity_reg);
            res_pix_reg <= '0;
            res_hit_reg <= hit_c;
        end
        if (state_reg == ST_READ)
        begin
            sa_reg <= div255(prod_reg);
        end
        if (state_reg == ST_MUL && kind_reg == KIND_READ)
        begin
            res_pix_reg <= rdata_reg;
        end
        if (state_reg == ST_WB)
        begin
            res_pix_reg <= blended;
        end
        if (fin_go)
        begin
            result_reg.out_red   <= res_pix_reg.red;
            result_reg.out_green <= res_pix_reg.green;
            result_reg.out_blue  <= res_pix_reg.blue;
            result_reg.out_alpha <= res_pix_reg.alpha;
            result_reg.in_frame  <= res_hit_reg;
        end
    end

    cab_blend u_blend (
        .clk     (clk),
        .dst     (rdata_reg),
        .src     (src_reg),
        .sa      (sa_reg),
        .blended (blended)
    );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for clipped_alpha_blit: pixel write, read and clipped blend traffic.
`timescale 1ns / 1ps

module testbench;

    import cab_pkg::*;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    localparam int OPAQUE = PIX_MAX;
    localparam int NUM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int LONG_HOLD = 400;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t               row;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        in_item_t                px;
        bit                      typed;
        out_item_t               want;
    } plan_row_t;

    typedef struct {
        logic [8:0] w;
        logic [8:0] h;
        logic [8:0] x;
        logic [8:0] y;
        logic [7:0] op;
    } frame_setting_t;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    in_item_t               item;
    logic                   result_valid;
    logic                   result_ready;
    out_item_t              result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pixel_t     shadow_frame [MAX_W * MAX_H];
    logic [8:0] frame_w;
    logic [8:0] frame_h;
    logic [8:0] org_x;
    logic [8:0] org_y;
    logic [7:0] opac;

    out_item_t  awaited_pixels [$];
    plan_row_t  plan [$];
    bit         calm;
    bit         hold_long;
    int         fault_count;
    int         beats_seen;
    int         inside_count;
    int         reg_writes;
    int         kind_seen [4];
    int         cycle_count;

    clipped_alpha_blit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;

    always #10 clk = ~clk;

    function automatic out_item_t blit_outcome(input in_item_t px);
        out_item_t res;
        pixel_t    dst;
        int        tx;
        int        ty;
        int        ew;
        int        eh;
        int        sa;
        int        addr;
        bit        hit;
        res = '0;
        ew = (frame_w > 9'(MAX_W)) ? MAX_W : int'(frame_w);
        eh = (frame_h > 9'(MAX_H)) ? MAX_H : int'(frame_h);
        if (px.kind == KIND_BLEND)
        begin
            tx = int'($signed(org_x)) + int'(px.col);
            ty = int'($signed(org_y)) + int'(px.row);
        end
        else
        begin
            tx = int'(px.col);
            ty = int'(px.row);
        end
        hit = (tx >= 0) && (ty >= 0) && (tx < ew) && (ty < eh);
        if (px.kind == KIND_UNUSED || !hit)
            return res;
        addr = ty * MAX_W + tx;
        case (px.kind)
            KIND_WRITE:
                shadow_frame[addr] = {px.alpha, px.blue, px.green, px.red};
            KIND_READ:
                {res.out_alpha, res.out_blue, res.out_green, res.out_red} = shadow_frame[addr];
            default:
            begin
                dst = shadow_frame[addr];
                sa = int'(px.alpha) * int'(opac) / OPAQUE;
                dst.red   = 8'((int'(dst.red) * (OPAQUE - sa) + int'(px.red) * sa) / OPAQUE);
                dst.green = 8'((int'(dst.green) * (OPAQUE - sa) + int'(px.green) * sa) / OPAQUE);
                dst.blue  = 8'((int'(dst.blue) * (OPAQUE - sa) + int'(px.blue) * sa) / OPAQUE);
                dst.alpha = 8'(int'(dst.alpha) * (OPAQUE - sa) / OPAQUE + sa);
                shadow_frame[addr] = dst;
                {res.out_alpha, res.out_blue, res.out_green, res.out_red} = dst;
            end
        endcase
        res.in_frame = 1'b1;
        return res;
    endfunction

    function automatic int pause_len();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endtask

    task automatic offer(input in_item_t px, input bit typed, input out_item_t want);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= px;
        do @(posedge clk); while (!item_ready);
        if (typed)
        begin
            void'(blit_outcome(px));
            awaited_pixels.push_back(want);
        end
        else
            awaited_pixels.push_back(blit_outcome(px));
        kind_seen[px.kind]++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DEST_WIDTH:  frame_w = data;
            CFG_DEST_HEIGHT: frame_h = data;
            CFG_DEST_X:      org_x = data;
            CFG_DEST_Y:      org_y = data;
            CFG_OPACITY:     opac = data[7:0];
            default:         ;
        endcase
        reg_writes++;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     awaited_pixels.size());
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin : beat_check
        out_item_t want;
        if (result_valid && result_ready)
        begin
            beats_seen++;
            if (awaited_pixels.size() == 0)
            begin
                $error("result beat with no item outstanding: %h", result);
                fault_count++;
            end
            else
            begin
                want = awaited_pixels.pop_front();
                if (result.in_frame)
                    inside_count++;
                check_field("out_red", want.out_red, result.out_red);
                check_field("out_green", want.out_green, result.out_green);
                check_field("out_blue", want.out_blue, result.out_blue);
                check_field("out_alpha", want.out_alpha, result.out_alpha);
                check_field("in_frame", want.in_frame, result.in_frame);
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        forever
        begin
            if (hold_long)
            begin
                hold_long = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = pause_len();
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    initial
    begin : stimulus
        frame_setting_t layouts [NUM_PHASES];
        frame_setting_t s;
        in_item_t       px;
        int             i;
        int             p;
        int             n;
        int             k;
        int             pick;
        int             tx;
        int             ty;
        int             cx;
        int             cy;
        int             ew;
        int             eh;
        int             hot_x;
        int             hot_y;

        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        for (i = 0; i < MAX_W * MAX_H; i++)
            shadow_frame[i] = '0;
        frame_w = 9'd256;
        frame_h = 9'd256;
        org_x = 9'd0;
        org_y = 9'd0;
        opac = 8'd255;
        hot_x = 0;
        hot_y = 0;

        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd0, 8'd0, 32'd0}, 1'b1, {32'd0, 1'b1}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd255, 8'd255, 32'd0}, 1'b1,
                         {32'd0, 1'b1}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_WRITE, 8'd0, 8'd0, 32'hFFFFFFFF}, 1'b1,
                         {32'd0, 1'b1}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd0, 8'd0, 32'd0}, 1'b1,
                         {32'hFFFFFFFF, 1'b1}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_WRITE, 8'd255, 8'd255, 32'h12345678}, 1'b1,
                         {32'd0, 1'b1}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd255, 8'd255, 32'd0}, 1'b1,
                         {32'h12345678, 1'b1}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_UNUSED, 8'd255, 8'd255, 32'hFFFFFFFF}, 1'b1,
                         {32'd0, 1'b0}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_BLEND, 8'd255, 8'd255, 32'hAA55A500}, 1'b1,
                         {32'h12345678, 1'b1}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_BLEND, 8'd0, 8'd0, 32'h010203FF}, 1'b1,
                         {32'h010203FF, 1'b1}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_WRITE, 8'd1, 8'd0, 32'h80402080}, 1'b1,
                         {32'd0, 1'b1}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_BLEND, 8'd1, 8'd0, 32'h00FF5580}, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_BLEND, 8'd1, 8'd0, 32'h3CC30F7F}, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd1, 8'd0, 32'd0}, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_OPACITY, 9'd0, '0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_BLEND, 8'd0, 8'd0, 32'h778899FF}, 1'b1,
                         {32'h010203FF, 1'b1}});
        plan.push_back('{ROW_CFG, CFG_OPACITY, 9'd128, '0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_BLEND, 8'd0, 8'd0, 32'hF00F80C8}, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_DEST_X, 9'h100, '0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_BLEND, 8'd255, 8'd0, 32'h11223344}, 1'b1,
                         {32'd0, 1'b0}});
        plan.push_back('{ROW_CFG, CFG_DEST_X, 9'h101, '0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_DEST_Y, 9'h0FF, '0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_BLEND, 8'd255, 8'd0, 32'h55667788}, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_BLEND, 8'd255, 8'd1, 32'h99AABBCC}, 1'b1,
                         {32'd0, 1'b0}});
        plan.push_back('{ROW_CFG, CFG_DEST_WIDTH, 9'd1, '0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_DEST_HEIGHT, 9'd1, '0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd1, 8'd0, 32'd0}, 1'b1, {32'd0, 1'b0}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_WRITE, 8'd0, 8'd1, 32'hDEADBEEF}, 1'b1,
                         {32'd0, 1'b0}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd0, 8'd0, 32'd0}, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_DEST_WIDTH, 9'd256, '0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_DEST_HEIGHT, 9'd256, '0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd1, 8'd0, 32'd0}, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd0, 8'd1, 32'd0}, 1'b1, {32'd0, 1'b1}});
        plan.push_back('{ROW_CFG, CFG_DEST_WIDTH, 9'd0, '0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_WRITE, 8'd0, 8'd0, 32'd0}, 1'b1, {32'd0, 1'b0}});
        plan.push_back('{ROW_ITEM, '0, '0, {KIND_READ, 8'd0, 8'd0, 32'd0}, 1'b1, {32'd0, 1'b0}});

        layouts[0] = '{9'd256, 9'd256, 9'h000, 9'h000, 8'd255};
        layouts[1] = '{9'd256, 9'd256, 9'h100, 9'h100, 8'd255};
        layouts[2] = '{9'd256, 9'd256, 9'h0FF, 9'h0FF, 8'd0};
        layouts[3] = '{9'd1, 9'd1, 9'h000, 9'h000, 8'd128};
        layouts[4] = '{9'd256, 9'd256, 9'h1F0, 9'h010, 8'd200};
        layouts[5] = '{9'd0, 9'd256, 9'h000, 9'h000, 8'd255};
        layouts[6] = '{9'd256, 9'd0, 9'h020, 9'h1E0, 8'd1};
        for (p = 7; p < NUM_PHASES; p++)
            layouts[p] = '{9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                           9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                           8'($urandom_range(0, 255))};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].row == ROW_CFG)
            begin
                if (i > 0 && plan[i - 1].row == ROW_ITEM)
                    settle();
                put_reg(plan[i].idx, plan[i].data);
                if (i + 1 == plan.size() || plan[i + 1].row != ROW_CFG)
                    cfg_valid <= 1'b0;
            end
            else
                offer(plan[i].px, plan[i].typed, plan[i].want);
        end
        settle();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            s = layouts[p];
            put_reg(CFG_DEST_WIDTH, s.w);
            put_reg(CFG_DEST_HEIGHT, s.h);
            put_reg(CFG_DEST_X, s.x);
            put_reg(CFG_DEST_Y, s.y);
            put_reg(CFG_OPACITY, {1'b0, s.op});
            cfg_valid <= 1'b0;
            calm = (p % 3 == 1);
            if (p == 4)
                hold_long = 1'b1;
            ew = (frame_w > 9'(MAX_W)) ? MAX_W : int'(frame_w);
            eh = (frame_h > 9'(MAX_H)) ? MAX_H : int'(frame_h);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                k = $urandom_range(0, 19);
                px.kind = (k < 6) ? KIND_WRITE : (k < 11) ? KIND_READ :
                          (k < 19) ? KIND_BLEND : KIND_UNUSED;
                pick = $urandom_range(0, 9);
                if (pick < 2 || ew == 0 || eh == 0)
                begin
                    px.col = 8'($urandom);
                    px.row = 8'($urandom);
                end
                else
                begin
                    if (pick < 6)
                    begin
                        tx = hot_x;
                        ty = hot_y;
                    end
                    else
                    begin
                        tx = $urandom_range(0, ew - 1);
                        ty = $urandom_range(0, eh - 1);
                        hot_x = tx;
                        hot_y = ty;
                    end
                    cx = (px.kind == KIND_BLEND) ? tx - int'($signed(org_x)) : tx;
                    cy = (px.kind == KIND_BLEND) ? ty - int'($signed(org_y)) : ty;
                    if (cx < 0 || cx > 255)
                        cx = $urandom_range(0, 255);
                    if (cy < 0 || cy > 255)
                        cy = $urandom_range(0, 255);
                    px.col = 8'(cx);
                    px.row = 8'(cy);
                end
                px.red = 8'($urandom);
                px.green = 8'($urandom);
                px.blue = 8'($urandom);
                case ($urandom_range(0, 5))
                    0:       px.alpha = 8'h00;
                    1:       px.alpha = 8'hFF;
                    default: px.alpha = 8'($urandom);
                endcase
                offer(px, 1'b0, '0);
            end
            settle();
        end

        calm = 1'b0;
        repeat (16) @(posedge clk);
        $display("summary: %0d writes, %0d reads, %0d blends, %0d unused-kind items, %0d register writes",
                 kind_seen[KIND_WRITE], kind_seen[KIND_READ], kind_seen[KIND_BLEND],
                 kind_seen[KIND_UNUSED], reg_writes);
        $display("summary: %0d result beats checked, %0d inside the frame, %0d mismatches",
                 beats_seen, inside_count, fault_count);
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
